@@ rtl/core/utf8_codepoint_decoder_unit_defines.svh @@
// Assertion macros for the UTF-8 code point decoder.
`ifndef UTF8_CODEPOINT_DECODER_UNIT_DEFINES_SVH
`define UTF8_CODEPOINT_DECODER_UNIT_DEFINES_SVH

// Checked only while reset is low.
`define UCD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Checked at every edge, reset included.
`define UCD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

@@ rtl/core/ucd_pkg.sv @@
// Shared types and constants for the UTF-8 code point decoder.
package ucd_pkg;

   localparam int unsigned ByteWidth    = 8;
   localparam int unsigned CpWidth      = 21;
   localparam int unsigned PartialWidth = 15;
   localparam int unsigned PendWidth    = 2;

   typedef logic [PendWidth-1:0] pend_type;

   localparam pend_type PEND_NONE  = 2'd0;
   localparam pend_type PEND_ONE   = 2'd1;
   localparam pend_type PEND_TWO   = 2'd2;
   localparam pend_type PEND_THREE = 2'd3;

   // One request as held in the input register.
   typedef struct packed {
      logic [ByteWidth-1:0] data_byte;
      logic                 last_byte;
   } ucd_byte_type;

   // Decoder output toward the result register.
   typedef struct packed {
      logic               emit;
      logic [CpWidth-1:0] code_point;
      logic               end_of_text;
   } ucd_result_type;

endpackage

@@ rtl/core/ucd_in_reg.sv @@
// Input register stage for the UTF-8 code point decoder.
module ucd_in_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  logic                advance,
   input  ucd_pkg::ucd_byte_type in_data,
   output logic                valid,
   output ucd_pkg::ucd_byte_type out_data
);
   import ucd_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   ucd_byte_type data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= in_data;
      end
   end

   assign valid    = valid_ff;
   assign out_data = data_ff;

endmodule

@@ rtl/core/ucd_decode.sv @@
// Sequence state and per-byte decode logic.
module ucd_decode (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  ucd_pkg::ucd_byte_type in_data,
   output ucd_pkg::ucd_result_type result
);
   import ucd_pkg::*;

   pend_type                pending_ff;
   pend_type                pending_in;
   logic [PartialWidth-1:0] partial_ff;
   logic [PartialWidth-1:0] partial_in;

   logic [ByteWidth-1:0]    b;
   logic                    is_cont;
   logic [CpWidth-1:0]      merged;
   pend_type                pending_dec;

   always_comb begin
      b           = in_data.data_byte;
      is_cont     = (pending_ff != PEND_NONE) && (b[7:6] == 2'b10);
      merged      = {partial_ff, b[5:0]};
      pending_dec = pending_ff - PEND_ONE;

      pending_in         = PEND_NONE;
      partial_in         = '0;
      result.emit        = 1'b0;
      result.code_point  = '0;
      result.end_of_text = in_data.last_byte;

      if (is_cont) begin
         pending_in = pending_dec;
         if (pending_dec == PEND_NONE) begin
            result.emit       = 1'b1;
            result.code_point = merged;
         end else begin
            partial_in = merged[PartialWidth-1:0];
         end
      end else if (!b[7]) begin
         result.emit       = 1'b1;
         result.code_point = {{(CpWidth-ByteWidth){1'b0}}, b};
      end else if (b[7:5] == 3'b110) begin
         partial_in = {{(PartialWidth-5){1'b0}}, b[4:0]};
         pending_in = PEND_ONE;
      end else if (b[7:4] == 4'b1110) begin
         partial_in = {{(PartialWidth-4){1'b0}}, b[3:0]};
         pending_in = PEND_TWO;
      end else if (b[7:3] == 5'b11110) begin
         partial_in = {{(PartialWidth-3){1'b0}}, b[2:0]};
         pending_in = PEND_THREE;
      end
      // lone continuation and 0xF8-0xFF fall through: dropped

      if (in_data.last_byte) begin
         pending_in = PEND_NONE;
         partial_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= PEND_NONE;
         partial_ff <= '0;
      end else if (step) begin
         pending_ff <= pending_in;
         partial_ff <= partial_in;
      end
   end

endmodule

@@ rtl/core/ucd_out_reg.sv @@
// Result register for decoded code points.
module ucd_out_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  logic                   stall,
   input  ucd_pkg::ucd_result_type in_data,
   output logic                   valid,
   output logic                   free,
   output logic [ucd_pkg::CpWidth-1:0] code_point,
   output logic                   end_of_text
);
   import ucd_pkg::*;

   logic               valid_ff;
   logic               valid_in;
   logic [CpWidth-1:0] cp_ff;
   logic               eot_ff;

   assign free = !valid_ff || !stall;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (free) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cp_ff  <= in_data.code_point;
         eot_ff <= in_data.end_of_text;
      end
   end

   assign valid       = valid_ff;
   assign code_point  = cp_ff;
   assign end_of_text = eot_ff;

endmodule

@@ rtl/core/utf8_codepoint_decoder_unit.sv @@
// Top level of the UTF-8 code point decoder.
//
// Request channel (req_): one byte of UTF-8 text per request, with
// req_last_byte set on the final byte of a text. Response channel (rsp_):
// one decoded code point, with rsp_end_of_text set when the byte that
// completed it carried req_last_byte. Bytes that complete no code point
// (lead bytes, middle continuations, dropped bytes) give no response.
// A request is taken when valid is high and stall is low.
//
// Pipeline: a request is taken into the input register, and the code point
// that it completes is loaded into the response register once that register
// is free. Throughput: one byte per cycle while req_stall is low, set by the
// single decode stage between the input register and the response register.
//
// Reset clears the open sequence and both registers; req_stall is high
// while reset is asserted. When the receiver stalls, the response holds;
// bytes that give no response still pass, and req_stall rises only when a
// code point is waiting behind a stalled response.
module utf8_codepoint_decoder_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [ucd_pkg::ByteWidth-1:0] req_data_byte,
   input  logic                          req_last_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ucd_pkg::CpWidth-1:0]   rsp_code_point,
   output logic                          rsp_end_of_text
);
   import ucd_pkg::*;

   ucd_byte_type   req_data;
   ucd_byte_type   stage_data;
   ucd_result_type dec_result;
   logic           stage_valid;
   logic           out_free;
   logic           advance;
   logic           accept;

   assign req_data.data_byte = req_data_byte;
   assign req_data.last_byte = req_last_byte;

   // a byte with no code point never waits for the response register
   assign advance   = stage_valid && (!dec_result.emit || out_free);
   assign req_stall = reset || (stage_valid && !advance);
   assign accept    = req_valid && !req_stall;

   ucd_in_reg u_in_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (accept),
      .advance  (advance),
      .in_data  (req_data),
      .valid    (stage_valid),
      .out_data (stage_data)
   );

   ucd_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .in_data (stage_data),
      .result  (dec_result)
   );

   ucd_out_reg u_out_reg (
      .clock       (clock),
      .reset       (reset),
      .load        (advance && dec_result.emit),
      .stall       (rsp_stall),
      .in_data     (dec_result),
      .valid       (rsp_valid),
      .free        (out_free),
      .code_point  (rsp_code_point),
      .end_of_text (rsp_end_of_text)
   );

endmodule

@@ rtl/core/ucd_checker.sv @@
// Port-level checks for the UTF-8 code point decoder, bound to the top level.
`include "utf8_codepoint_decoder_unit_defines.svh"

module ucd_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [ucd_pkg::CpWidth-1:0] rsp_code_point,
   input logic                        rsp_end_of_text
);

   `UCD_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid, "response dropped while stalled")
   `UCD_ASSERT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall |=> $stable(rsp_code_point) && $stable(rsp_end_of_text), "stalled response changed")
   `UCD_ASSERT(a_no_false_stall, clock, reset, !rsp_stall |-> !req_stall, "request stalled with receiver free")
   `UCD_ASSERT(a_rsp_source, clock, reset, $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2), "response without request two cycles before")
   `UCD_ASSERT_ALWAYS(a_reset_clear, clock, reset |=> !rsp_valid, "response valid after reset")

endmodule

bind utf8_codepoint_decoder_unit ucd_checker u_ucd_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_code_point  (rsp_code_point),
   .rsp_end_of_text (rsp_end_of_text)
);

@@ bench/utf8_codepoint_decoder_unit_tb.sv @@
// Self-checking testbench for the UTF-8 code point decoder.
module utf8_codepoint_decoder_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ucd_pkg::*;

   typedef struct packed {
      logic [CpWidth-1:0] code_point;
      logic               end_of_text;
   } cp_rec_type;

   typedef struct packed {
      logic [ByteWidth-1:0] data;
      logic                 last;
   } text_byte_type;

   // Directed row: typed == 1 means the expectation is given here, not predicted.
   typedef struct packed {
      logic [ByteWidth-1:0] data;
      logic                 last;
      logic                 typed;
      logic                 typed_emit;
      logic [CpWidth-1:0]   typed_cp;
   } directed_row_type;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [ByteWidth-1:0] req_data_byte = '0;
   logic                 req_last_byte = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [CpWidth-1:0]   rsp_code_point;
   logic                 rsp_end_of_text;

   // Predictor state: continuation bytes still owed and payload gathered so far.
   pend_type                open_count = PEND_NONE;
   logic [PartialWidth-1:0] gathered_bits = '0;

   cp_rec_type    expected_cps[$];
   text_byte_type text_stream[$];
   int            fails = 0;
   int            delivered = 0;
   int            burst_left = 0;

   directed_row_type directed_rows [26] = '{
      '{8'h00, 1'b0, 1'b1, 1'b1, 21'h000000},
      '{8'h7F, 1'b1, 1'b1, 1'b1, 21'h00007F},
      '{8'h80, 1'b0, 1'b1, 1'b0, 21'h000000},   // lone continuation
      '{8'hF8, 1'b0, 1'b1, 1'b0, 21'h000000},   // invalid lead
      '{8'hFF, 1'b0, 1'b1, 1'b0, 21'h000000},
      '{8'hC2, 1'b0, 1'b0, 1'b0, 21'h000000},
      '{8'hA9, 1'b0, 1'b0, 1'b0, 21'h000000},
      '{8'hE2, 1'b0, 1'b0, 1'b0, 21'h000000},
      '{8'h82, 1'b0, 1'b0, 1'b0, 21'h000000},
      '{8'hAC, 1'b0, 1'b0, 1'b0, 21'h000000},
      '{8'hF0, 1'b0, 1'b0, 1'b0, 21'h000000},
      '{8'h9F, 1'b0, 1'b0, 1'b0, 21'h000000},
      '{8'h98, 1'b0, 1'b0, 1'b0, 21'h000000},
      '{8'h80, 1'b1, 1'b0, 1'b0, 21'h000000},   // four-byte sequence ends the text
      '{8'hF7, 1'b0, 1'b0, 1'b0, 21'h000000},
      '{8'hBF, 1'b0, 1'b0, 1'b0, 21'h000000},
      '{8'hBF, 1'b0, 1'b0, 1'b0, 21'h000000},
      '{8'hBF, 1'b0, 1'b1, 1'b1, 21'h1FFFFF},   // largest code point
      '{8'hE0, 1'b0, 1'b0, 1'b0, 21'h000000},
      '{8'h80, 1'b0, 1'b0, 1'b0, 21'h000000},
      '{8'h41, 1'b0, 1'b0, 1'b0, 21'h000000},   // ASCII cuts the open sequence
      '{8'hC3, 1'b0, 1'b0, 1'b0, 21'h000000},
      '{8'hFF, 1'b0, 1'b1, 1'b0, 21'h000000},   // invalid lead drops the open sequence
      '{8'hBF, 1'b0, 1'b1, 1'b0, 21'h000000},   // now a lone continuation
      '{8'hE1, 1'b1, 1'b1, 1'b0, 21'h000000},   // end of text with a sequence open
      '{8'h81, 1'b0, 1'b1, 1'b0, 21'h000000}
   };

   utf8_codepoint_decoder_unit DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_last_byte   (req_last_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_code_point  (rsp_code_point),
      .rsp_end_of_text (rsp_end_of_text)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   function automatic void add_expected(input cp_rec_type r);
      expected_cps = {expected_cps, r};
   endfunction

   function automatic void add_text_byte(input text_byte_type t);
      text_stream = {text_stream, t};
   endfunction

   function automatic void decode_byte(input logic [ByteWidth-1:0] b, input logic last,
                                       output logic emit, output logic [CpWidth-1:0] cp);
      logic [CpWidth-1:0] grown;
      emit = 1'b0;
      cp   = '0;
      if (open_count != PEND_NONE && b[7:6] == 2'b10) begin
         grown      = {gathered_bits, b[5:0]};
         open_count = open_count - 2'd1;
         if (open_count == PEND_NONE) begin
            cp            = grown;
            emit          = 1'b1;
            gathered_bits = '0;
         end else begin
            gathered_bits = grown[PartialWidth-1:0];
         end
      end else begin
         open_count    = PEND_NONE;
         gathered_bits = '0;
         if (!b[7]) begin
            cp   = CpWidth'(b);
            emit = 1'b1;
         end else if (b[7:5] == 3'b110) begin
            gathered_bits = PartialWidth'(b[4:0]);
            open_count    = PEND_ONE;
         end else if (b[7:4] == 4'b1110) begin
            gathered_bits = PartialWidth'(b[3:0]);
            open_count    = PEND_TWO;
         end else if (b[7:3] == 5'b11110) begin
            gathered_bits = PartialWidth'(b[2:0]);
            open_count    = PEND_THREE;
         end
      end
      if (last) begin
         open_count    = PEND_NONE;
         gathered_bits = '0;
      end
   endfunction

   // Entered and left at a falling edge.
   task automatic send_byte(input logic [ByteWidth-1:0] b, input logic l, input logic typed,
                            input logic typed_emit, input logic [CpWidth-1:0] typed_cp);
      logic               emit;
      logic [CpWidth-1:0] cp;
      int                 gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= l;
      do @(posedge clock); while (req_stall);
      decode_byte(b, l, emit, cp);
      if (typed) begin
         emit = typed_emit;
         cp   = typed_cp;
      end
      if (emit)
         add_expected(cp_rec_type'{cp, l});
      @(negedge clock);
   endtask

   // Sender: directed rows, then random texts.
   initial begin
      int units;
      int kind;
      int seq_len;
      int conts;
      logic [ByteWidth-1:0] lead;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i])
         send_byte(directed_rows[i].data, directed_rows[i].last, directed_rows[i].typed,
                   directed_rows[i].typed_emit, directed_rows[i].typed_cp);

      // Mostly well-formed text, with truncated sequences and stray bytes mixed in.
      while (text_stream.size() < 720) begin
         units = $urandom_range(1, 12);
         for (int u = 0; u < units; u++) begin
            kind = $urandom_range(0, 9);
            if (kind <= 5 || kind == 7) begin
               seq_len = (kind == 7) ? $urandom_range(2, 4) : $urandom_range(1, 4);
               case (seq_len)
                  1: lead = ByteWidth'($urandom_range(0, 127));
                  2: lead = 8'hC0 | ByteWidth'($urandom_range(0, 31));
                  3: lead = 8'hE0 | ByteWidth'($urandom_range(0, 15));
                  default: lead = 8'hF0 | ByteWidth'($urandom_range(0, 7));
               endcase
               conts = (kind == 7) ? $urandom_range(0, seq_len - 2) : seq_len - 1;
               add_text_byte(text_byte_type'{lead, 1'b0});
               repeat (conts)
                  add_text_byte(text_byte_type'{8'h80 | ByteWidth'($urandom_range(0, 63)),
                                                1'b0});
            end else if (kind == 6) begin
               add_text_byte(text_byte_type'{ByteWidth'($urandom_range(0, 255)), 1'b0});
            end else if (kind == 8) begin
               add_text_byte(text_byte_type'{8'h80 | ByteWidth'($urandom_range(0, 63)),
                                             1'b0});
            end else begin
               add_text_byte(text_byte_type'{8'hF8 | ByteWidth'($urandom_range(0, 7)),
                                             1'b0});
            end
         end
         text_stream[text_stream.size() - 1].last = 1'b1;
      end

      foreach (text_stream[i])
         send_byte(text_stream[i].data, text_stream[i].last, 1'b0, 1'b0, '0);
      req_valid <= 1'b0;

      while (expected_cps.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (fails == 0 && expected_cps.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Receiver: stall pattern drawn from one of four modes, plus one long hold-off.
   initial begin
      int cyc;
      int mode;
      int hold_left;
      bit held_once;
      cyc       = 0;
      mode      = 0;
      hold_left = 0;
      held_once = 1'b0;
      forever begin
         @(negedge clock);
         if (!held_once && delivered >= 150) begin
            held_once = 1'b1;
            hold_left = 120;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            if (cyc % 64 == 0)
               mode = $urandom_range(0, 3);
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= 1'($urandom_range(0, 1));
               default: rsp_stall <= (cyc % 5 < 2);
            endcase
         end
         cyc++;
      end
   end

   always @(posedge clock) begin
      cp_rec_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         delivered++;
         if (expected_cps.size() == 0) begin
            $error("unexpected response: code_point %h end_of_text %b",
                   rsp_code_point, rsp_end_of_text);
            fails++;
         end else begin
            want = expected_cps.pop_front();
            if (rsp_code_point !== want.code_point) begin
               $error("code_point: expected %h, actual %h", want.code_point, rsp_code_point);
               fails++;
            end
            if (rsp_end_of_text !== want.end_of_text) begin
               $error("end_of_text: expected %b, actual %b", want.end_of_text,
                      rsp_end_of_text);
               fails++;
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/ucd_pkg.sv
rtl/core/ucd_in_reg.sv
rtl/core/ucd_decode.sv
rtl/core/ucd_out_reg.sv
rtl/core/utf8_codepoint_decoder_unit.sv
rtl/core/ucd_checker.sv
bench/utf8_codepoint_decoder_unit_tb.sv
